// ===== src/multiturn_angle_velocity_tracker_unit_macros.svh =====
// assertion macros shared by the tracker rtl
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_UNIT_MACROS_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MAVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MAVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mavt_pkg.sv =====
// types, constants and helpers of the multiturn angle and velocity tracker
package mavt_pkg;

  // sizing
  localparam int COUNT_BITS = 16;
  localparam int TURN_BITS  = 16;
  localparam int TIME_BITS  = 32;

  // field and register widths
  localparam int RAW_W      = 16;
  localparam int TIME_IN_W  = 32;
  localparam int ANGLE_W    = 40;
  localparam int VEL_W      = 48;
  localparam int TURN_OUT_W = 16;
  localparam int CPR_W      = 17;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // arithmetic constants
  localparam int TWO_PI_Q16   = 411775;
  localparam int USEC_PER_SEC = 1000000;
  localparam int TA_W         = TURN_BITS + 20;
  localparam int SUM_W        = 48;
  localparam int MAG_W        = ANGLE_W + 1;
  localparam int NUM_W        = 61;
  localparam int QUO_W        = 48;
  localparam int LO_W         = 52;
  localparam int DIV_STEPS    = QUO_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  // register reset values
  localparam logic [CPR_W-1:0] CPR_RST      = CPR_W'(16384);
  localparam logic [CFG_W-1:0] RPC_RST      = CFG_W'(1647099);
  localparam logic [CFG_W-1:0] MAX_INT_RST  = CFG_W'(500000);
  localparam logic [CFG_W-1:0] FALLBACK_RST = CFG_W'(1000);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPR      = 2'd0,
    REG_RPC      = 2'd1,
    REG_MAX_INT  = 2'd2,
    REG_FALLBACK = 2'd3
  } cfg_reg_e;

  // item opcodes
  typedef enum logic {
    OP_INIT   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TURN,
    ST_ANGLE,
    ST_DELTA,
    ST_MLO,
    ST_MHI,
    ST_NUM,
    ST_DIV,
    ST_VEL
  } state_e;

  // saturate a wide signed value to the angle range
  function automatic logic signed [ANGLE_W-1:0] clamp_angle(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-ANGLE_W:0] top;
    logic signed [ANGLE_W-1:0] res;
    top = v[SUM_W-1:ANGLE_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[ANGLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ANGLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== src/mavt_in_if.sv =====
// input channel: opcode, raw count and timestamp
interface mavt_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [mavt_pkg::RAW_W-1:0]         raw_count;
  logic [mavt_pkg::TIME_IN_W-1:0]     time_us;

  modport source (output valid, output opcode, output raw_count, output time_us,
                  input ready);
  modport sink   (input valid, input opcode, input raw_count, input time_us,
                  output ready);
endinterface

// ===== src/mavt_out_if.sv =====
// output channel: angle, velocity and turn count
interface mavt_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mavt_pkg::ANGLE_W-1:0]     angle_q16;
  logic signed [mavt_pkg::VEL_W-1:0]       velocity_q16;
  logic signed [mavt_pkg::TURN_OUT_W-1:0]  turn_count;

  modport source (output valid, output angle_q16, output velocity_q16, output turn_count,
                  input ready);
  modport sink   (input valid, input angle_q16, input velocity_q16, input turn_count,
                  output ready);
endinterface

// ===== src/multiturn_angle_velocity_tracker_unit.sv =====
// multiturn angle unwrap and velocity tracker, top level
//
// Usage: each input word carries an opcode, a raw absolute-encoder count and
// a microsecond timestamp; each one gives exactly one output word with the
// Q16.16 multi-turn angle, the Q16.16 velocity and the turn counter.
// Configuration registers are written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i while the unit is idle, a rule the block does not enforce.
// Steps: a sample word passes through count times scale on one shared 32x32
// multiplier, angle, delta, two more multiplier passes for delta times 1e6,
// dividend, then a radix-4 divider pass; an init word takes only the turn,
// angle and delta steps, and a sample whose velocity saturates skips the
// divider. One word is worked on at a time; in_i.ready is high only in the
// idle state, so a new sample is taken only once the previous word is through.
// The result sits in an output register, so the unit returns to idle and
// takes the next word while that result waits; a new result is held back
// only while the previous one is still not taken.
// Reset: all tracker state is zero and the registers take their defaults;
// no word is pending.
module multiturn_angle_velocity_tracker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mavt_in_if.sink                            in_i,
  mavt_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [mavt_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [mavt_pkg::CFG_W-1:0]         cfg_wdata_i
);

  `include "multiturn_angle_velocity_tracker_unit_macros.svh"

  localparam logic signed [mavt_pkg::TURN_BITS-1:0] TurnMax =
    {1'b0, {(mavt_pkg::TURN_BITS-1){1'b1}}};
  localparam logic signed [mavt_pkg::TURN_BITS-1:0] TurnMin =
    {1'b1, {(mavt_pkg::TURN_BITS-1){1'b0}}};
  localparam logic signed [mavt_pkg::VEL_W-1:0] VelMax =
    {1'b0, {(mavt_pkg::VEL_W-1){1'b1}}};
  localparam logic signed [mavt_pkg::VEL_W-1:0] VelMin =
    {1'b1, {(mavt_pkg::VEL_W-1){1'b0}}};
  localparam logic [mavt_pkg::DIV_CNT_W-1:0] DivLast =
    mavt_pkg::DIV_CNT_W'(mavt_pkg::DIV_STEPS - 1);

  // configuration registers
  logic [mavt_pkg::CPR_W-1:0] cpr_q;
  logic [mavt_pkg::CFG_W-1:0] rpc_q;
  logic [mavt_pkg::CFG_W-1:0] max_int_q;
  logic [mavt_pkg::CFG_W-1:0] fallback_q;

  // tracker state
  logic [mavt_pkg::COUNT_BITS-1:0]        last_count_q;
  logic signed [mavt_pkg::TURN_BITS-1:0]  turns_q;
  logic signed [mavt_pkg::TA_W-1:0]       turn_angle_q;
  logic signed [mavt_pkg::ANGLE_W-1:0]    last_angle_q;
  logic [mavt_pkg::TIME_BITS-1:0]         last_time_q;

  // sequencer and datapath
  mavt_pkg::state_e state_q, state_d;
  logic                                   op_q;
  logic [mavt_pkg::COUNT_BITS-1:0]        count_q;
  logic [mavt_pkg::TIME_BITS-1:0]         now_q;
  logic [mavt_pkg::CFG_W-1:0]             dt_q;
  logic [63:0]                            mul_q;
  logic [31:0]                            mul_a, mul_b;
  logic signed [mavt_pkg::ANGLE_W-1:0]    angle_q;
  logic                                   neg_q;
  logic [mavt_pkg::MAG_W-1:0]             mag_q;
  logic [mavt_pkg::LO_W-1:0]              lo_q;
  logic [mavt_pkg::CFG_W-1:0]             rem_q;
  logic [mavt_pkg::QUO_W-1:0]             quo_q;
  logic                                   sat_q;
  logic [mavt_pkg::DIV_CNT_W-1:0]         div_cnt_q;

  // output register
  logic                                   out_valid_q, out_valid_d;
  logic signed [mavt_pkg::ANGLE_W-1:0]    out_angle_q;
  logic signed [mavt_pkg::VEL_W-1:0]      out_vel_q;
  logic signed [mavt_pkg::TURN_OUT_W-1:0] out_turn_q;

  logic in_fire;
  logic out_load;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q      <= mavt_pkg::CPR_RST;
      rpc_q      <= mavt_pkg::RPC_RST;
      max_int_q  <= mavt_pkg::MAX_INT_RST;
      fallback_q <= mavt_pkg::FALLBACK_RST;
    end else if (cfg_we_i) begin
      case (mavt_pkg::cfg_reg_e'(cfg_addr_i))
        mavt_pkg::REG_CPR:      cpr_q      <= cfg_wdata_i[mavt_pkg::CPR_W-1:0];
        mavt_pkg::REG_RPC:      rpc_q      <= cfg_wdata_i;
        mavt_pkg::REG_MAX_INT:  max_int_q  <= cfg_wdata_i;
        mavt_pkg::REG_FALLBACK: fallback_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // wrap detection: 5*|d| > 4*cpr
  logic signed [mavt_pkg::COUNT_BITS:0] d_w;
  logic [mavt_pkg::COUNT_BITS-1:0]      d_mag;
  logic [mavt_pkg::COUNT_BITS+2:0]      d_mag5;
  logic [mavt_pkg::CPR_W+1:0]           cpr4;
  logic                                 wrap;
  assign d_w    = $signed({1'b0, count_q}) - $signed({1'b0, last_count_q});
  assign d_mag  = d_w[mavt_pkg::COUNT_BITS] ? mavt_pkg::COUNT_BITS'(-d_w)
                                            : d_w[mavt_pkg::COUNT_BITS-1:0];
  assign d_mag5 = {d_mag, 2'b00} + (mavt_pkg::COUNT_BITS+3)'(d_mag);
  assign cpr4   = {cpr_q, 2'b00};
  assign wrap   = (mavt_pkg::CPR_W+2)'(d_mag5) > cpr4;

  // interval selection with fallback
  logic [mavt_pkg::TIME_BITS-1:0] dt_raw;
  logic [mavt_pkg::CFG_W-1:0]     dt_ext;
  logic [mavt_pkg::CFG_W-1:0]     fb_eff;
  assign dt_raw = now_q - last_time_q;
  assign dt_ext = mavt_pkg::CFG_W'(dt_raw);
  assign fb_eff = (fallback_q == '0) ? mavt_pkg::CFG_W'(1) : fallback_q;

  // angle: turns * 2pi + rounded fraction
  logic [48:0]                          frac_rnd;
  logic [32:0]                          frac;
  logic signed [mavt_pkg::SUM_W-1:0]    angle_sum;
  assign frac_rnd  = 49'(mul_q[47:0]) + 49'(16'h8000);
  assign frac      = frac_rnd[48:16];
  assign angle_sum = mavt_pkg::SUM_W'(turn_angle_q) + $signed(mavt_pkg::SUM_W'(frac));

  // angle delta and magnitude
  logic signed [mavt_pkg::MAG_W-1:0] diff;
  assign diff = mavt_pkg::MAG_W'(angle_q) - mavt_pkg::MAG_W'(last_angle_q);

  // dividend from the two partial products
  logic [mavt_pkg::NUM_W-1:0] num;
  assign num = {mul_q[28:0], 32'b0} + mavt_pkg::NUM_W'(lo_q);

  // two restoring divider steps per cycle
  logic [32:0] r1, r2;
  logic        ge1, ge2;
  logic [31:0] r1s, r2s;
  assign r1  = {rem_q, quo_q[mavt_pkg::QUO_W-1]};
  assign ge1 = r1 >= {1'b0, dt_q};
  assign r1s = ge1 ? 32'(r1 - {1'b0, dt_q}) : r1[31:0];
  assign r2  = {r1s, quo_q[mavt_pkg::QUO_W-2]};
  assign ge2 = r2 >= {1'b0, dt_q};
  assign r2s = ge2 ? 32'(r2 - {1'b0, dt_q}) : r2[31:0];

  // velocity from quotient, sign and saturation
  logic                               vel_sat;
  logic signed [mavt_pkg::VEL_W-1:0]  vel_w;
  assign vel_sat = sat_q || quo_q[mavt_pkg::QUO_W-1];
  always_comb begin
    if (vel_sat) begin
      vel_w = neg_q ? VelMin : VelMax;
    end else if (neg_q) begin
      vel_w = mavt_pkg::VEL_W'(-quo_q);
    end else begin
      vel_w = quo_q;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      mavt_pkg::ST_TURN: begin
        mul_a = 32'(count_q);
        mul_b = rpc_q;
      end
      mavt_pkg::ST_MLO: begin
        mul_a = mag_q[31:0];
        mul_b = 32'(mavt_pkg::USEC_PER_SEC);
      end
      mavt_pkg::ST_MHI: begin
        mul_a = 32'(mag_q[mavt_pkg::MAG_W-1:32]);
        mul_b = 32'(mavt_pkg::USEC_PER_SEC);
      end
      default: ;
    endcase
  end

  // handshakes
  assign in_i.ready = (state_q == mavt_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == mavt_pkg::ST_VEL) && (!out_valid_q || out_o.ready);

  // next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mavt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = mavt_pkg::ST_TURN;
        end
      end
      mavt_pkg::ST_TURN:  state_d = mavt_pkg::ST_ANGLE;
      mavt_pkg::ST_ANGLE: state_d = mavt_pkg::ST_DELTA;
      mavt_pkg::ST_DELTA: begin
        state_d = (op_q == mavt_pkg::OP_INIT) ? mavt_pkg::ST_VEL : mavt_pkg::ST_MLO;
      end
      mavt_pkg::ST_MLO:   state_d = mavt_pkg::ST_MHI;
      mavt_pkg::ST_MHI:   state_d = mavt_pkg::ST_NUM;
      mavt_pkg::ST_NUM: begin
        state_d = (32'(num[mavt_pkg::NUM_W-1:mavt_pkg::QUO_W]) >= dt_q) ?
                  mavt_pkg::ST_VEL : mavt_pkg::ST_DIV;
      end
      mavt_pkg::ST_DIV: begin
        if (div_cnt_q == DivLast) begin
          state_d = mavt_pkg::ST_VEL;
        end
      end
      mavt_pkg::ST_VEL: begin
        if (out_load) begin
          state_d     = mavt_pkg::ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = mavt_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mavt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tracker state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      turns_q      <= '0;
      turn_angle_q <= '0;
      last_angle_q <= '0;
      last_time_q  <= '0;
    end else begin
      case (state_q)
        mavt_pkg::ST_TURN: begin
          last_count_q <= count_q;
          if (op_q == mavt_pkg::OP_INIT) begin
            turns_q      <= '0;
            turn_angle_q <= '0;
            last_time_q  <= '0;
          end else begin
            last_time_q <= now_q;
            if (wrap && d_w > 0 && turns_q != TurnMin) begin
              turns_q      <= turns_q - 1'b1;
              turn_angle_q <= turn_angle_q - mavt_pkg::TA_W'(mavt_pkg::TWO_PI_Q16);
            end else if (wrap && d_w < 0 && turns_q != TurnMax) begin
              turns_q      <= turns_q + 1'b1;
              turn_angle_q <= turn_angle_q + mavt_pkg::TA_W'(mavt_pkg::TWO_PI_Q16);
            end
          end
        end
        mavt_pkg::ST_DELTA: last_angle_q <= angle_q;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
    case (state_q)
      mavt_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_q    <= in_i.opcode;
          count_q <= in_i.raw_count[mavt_pkg::COUNT_BITS-1:0];
          now_q   <= in_i.time_us[mavt_pkg::TIME_BITS-1:0];
        end
      end
      mavt_pkg::ST_TURN: begin
        dt_q <= (dt_ext == '0 || dt_ext > max_int_q) ? fb_eff : dt_ext;
      end
      mavt_pkg::ST_ANGLE: angle_q <= mavt_pkg::clamp_angle(angle_sum);
      mavt_pkg::ST_DELTA: begin
        if (op_q == mavt_pkg::OP_INIT) begin
          neg_q <= 1'b0;
          sat_q <= 1'b0;
          quo_q <= '0;
        end else begin
          neg_q <= diff[mavt_pkg::MAG_W-1];
          mag_q <= diff[mavt_pkg::MAG_W-1] ? mavt_pkg::MAG_W'(-diff) : diff;
        end
      end
      mavt_pkg::ST_MHI: lo_q <= mul_q[mavt_pkg::LO_W-1:0];
      mavt_pkg::ST_NUM: begin
        sat_q     <= 32'(num[mavt_pkg::NUM_W-1:mavt_pkg::QUO_W]) >= dt_q;
        rem_q     <= 32'(num[mavt_pkg::NUM_W-1:mavt_pkg::QUO_W]);
        quo_q     <= num[mavt_pkg::QUO_W-1:0];
        div_cnt_q <= '0;
      end
      mavt_pkg::ST_DIV: begin
        rem_q     <= r2s;
        quo_q     <= {quo_q[mavt_pkg::QUO_W-3:0], ge1, ge2};
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_angle_q <= last_angle_q;
      out_vel_q   <= vel_w;
      out_turn_q  <= mavt_pkg::TURN_OUT_W'(turns_q);
    end
  end

  // output word
  assign out_o.valid        = out_valid_q;
  assign out_o.angle_q16    = out_angle_q;
  assign out_o.velocity_q16 = out_vel_q;
  assign out_o.turn_count   = out_turn_q;

  // turn angle kept as a running sum must match turns times two pi
  logic signed [mavt_pkg::TA_W-1:0] ta_chk;
  assign ta_chk = mavt_pkg::TA_W'(turns_q) * mavt_pkg::TA_W'(mavt_pkg::TWO_PI_Q16);

  `MAVT_ASSERT_NOW(a_turn_angle_sum, 1'b1, turn_angle_q == ta_chk,
                   "turn angle out of step with turn counter")
  `MAVT_ASSERT_NOW(a_div_rem_bound, state_q == mavt_pkg::ST_DIV, rem_q < dt_q,
                   "divider remainder not below divisor")
  `MAVT_ASSERT_NEXT(a_init_clears, state_q == mavt_pkg::ST_TURN && op_q == mavt_pkg::OP_INIT,
                    turns_q == '0 && last_time_q == '0,
                    "init word did not clear turns and time")
  `MAVT_ASSERT_NOW(a_out_from_vel, $rose(out_valid_q), $past(state_q) == mavt_pkg::ST_VEL,
                   "result word raised outside the velocity state")

endmodule
